>>> rtl/swse_pkg.sv
package swse_pkg;

  // Fixed sizes of the draw engine.
  localparam int MAX_RADIUS_DEF = 30;
  localparam int GLYPH_COUNT    = 95;
  localparam int GLYPH_COLS     = 5;
  localparam int GLYPH_ROWS     = 7;

  // Printable character range of the font and the substitute glyph.
  localparam logic [7:0] GLYPH_FIRST = 8'h20;
  localparam logic [7:0] GLYPH_LAST  = 8'h7E;
  localparam logic [7:0] GLYPH_SUBST = 8'h3F;

  // Draw command opcodes.
  localparam logic [1:0] OP_RECT   = 2'd0;
  localparam logic [1:0] OP_CIRCLE = 2'd1;
  localparam logic [1:0] OP_RRECT  = 2'd2;
  localparam logic [1:0] OP_CHAR   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_X_OFFSET      = 2'd0;
  localparam logic [1:0] REG_Y_OFFSET      = 2'd1;
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd2;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd3;

  // Configuration reset values.
  localparam logic [7:0]  RST_X_OFFSET      = 8'd1;
  localparam logic [7:0]  RST_Y_OFFSET      = 8'd26;
  localparam logic [10:0] RST_SCREEN_WIDTH  = 11'd160;
  localparam logic [10:0] RST_SCREEN_HEIGHT = 11'd80;

  // A classified command as it waits between the front and back parts.
  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [10:0] pos_x;
    logic signed [10:0] pos_y;
    logic signed [10:0] width;
    logic signed [10:0] height;
    logic [4:0]         radius;
    logic [15:0]        fg_color;
    logic [15:0]        bg_color;
    logic [6:0]         glyph;
    logic [3:0]         scale;
  } cmd_t;

  // Font: five column bytes per glyph, column 0 in the top byte, bit 0 is the top row.
  localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h082A1C2A08, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h085454543C, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040403C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h08082A1C08
  };

  // One column byte of a glyph.
  function automatic logic [7:0] glyph_column(input logic [6:0] idx, input logic [2:0] col);
    logic [39:0] row;
    row = GLYPH_ROM[idx];
    return row[39 - 8 * int'(col) -: 8];
  endfunction

endpackage

>>> rtl/shape_to_window_span_engine_unit.sv
// A rectangle is registered as a span and then emitted as its only result.
// One command is drawn at a time; the queue holds up to two more. A rounded-rectangle
// band goes through span and emit. Circle and rounded-rectangle rows go through a 5-step
// square root unit, then span and emit; the second cap row of a pair reuses the root.
// Glyph cells go through span and emit one at a time, for every cell of a character.
// Reset (synchronous): offsets 1 and 26, screen 160 x 80, queue empty, no result pending.
module shape_to_window_span_engine_unit #(
  parameter int MAX_RADIUS = swse_pkg::MAX_RADIUS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic signed [10:0] pos_x,
  input  logic signed [10:0] pos_y,
  input  logic signed [10:0] width,
  input  logic signed [10:0] height,
  input  logic [4:0]         radius,
  input  logic [15:0]        fg_color,
  input  logic [15:0]        bg_color,
  input  logic [7:0]         char_code,
  input  logic [3:0]         scale,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        x_start,
  output logic [15:0]        x_end,
  output logic [15:0]        y_start,
  output logic [15:0]        y_end,
  output logic [15:0]        pixel_color,
  output logic               draw,
  output logic               last
);

  logic [7:0]     x_offset;
  logic [7:0]     y_offset;
  logic [10:0]    screen_width;
  logic [10:0]    screen_height;
  logic           q_valid;
  logic           q_pop;
  swse_pkg::cmd_t q_cmd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset      <= swse_pkg::RST_X_OFFSET;
      y_offset      <= swse_pkg::RST_Y_OFFSET;
      screen_width  <= swse_pkg::RST_SCREEN_WIDTH;
      screen_height <= swse_pkg::RST_SCREEN_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swse_pkg::REG_X_OFFSET:     x_offset      <= cfg_data[7:0];
        swse_pkg::REG_Y_OFFSET:     y_offset      <= cfg_data[7:0];
        swse_pkg::REG_SCREEN_WIDTH: screen_width  <= cfg_data;
        default:                    screen_height <= cfg_data;
      endcase
    end
  end

  swse_front #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .width    (width),
    .height   (height),
    .radius   (radius),
    .fg_color (fg_color),
    .bg_color (bg_color),
    .char_code(char_code),
    .scale    (scale),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  swse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .x_off      (x_offset),
    .y_off      (y_offset),
    .scr_w      (screen_width),
    .scr_h      (screen_height),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .x_start    (x_start),
    .x_end      (x_end),
    .y_start    (y_start),
    .y_end      (y_end),
    .pixel_color(pixel_color),
    .draw       (draw),
    .last       (last)
  );

endmodule

>>> rtl/swse_front.sv
module swse_front #(
  parameter int MAX_RADIUS = swse_pkg::MAX_RADIUS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           opcode,
  input  logic signed [10:0]   pos_x,
  input  logic signed [10:0]   pos_y,
  input  logic signed [10:0]   width,
  input  logic signed [10:0]   height,
  input  logic [4:0]           radius,
  input  logic [15:0]          fg_color,
  input  logic [15:0]          bg_color,
  input  logic [7:0]           char_code,
  input  logic [3:0]           scale,
  output logic                 q_valid,
  output swse_pkg::cmd_t       q_cmd,
  input  logic                 q_pop
);

  swse_pkg::cmd_t fifo_mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic [1:0]     count_next;
  logic           push;
  swse_pkg::cmd_t cls;
  logic [7:0]     glyph_code;
  logic [7:0]     glyph_diff;

  // Classify the incoming command: saturate the radius and pick the glyph index.
  always_comb begin
    if (char_code < swse_pkg::GLYPH_FIRST || char_code > swse_pkg::GLYPH_LAST) begin
      glyph_code = swse_pkg::GLYPH_SUBST;
    end else begin
      glyph_code = char_code;
    end
    glyph_diff   = glyph_code - swse_pkg::GLYPH_FIRST;
    cls.opcode   = opcode;
    cls.pos_x    = pos_x;
    cls.pos_y    = pos_y;
    cls.width    = width;
    cls.height   = height;
    cls.radius   = (radius > 5'(MAX_RADIUS)) ? 5'(MAX_RADIUS) : radius;
    cls.fg_color = fg_color;
    cls.bg_color = bg_color;
    cls.glyph    = glyph_diff[6:0];
    cls.scale    = scale;
  end

  // Two-entry command queue toward the back part.
  assign in_ready   = (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign q_valid    = (count != 2'd0);
  assign q_cmd      = fifo_mem[rd_ptr];
  assign count_next = count + 2'(push) - 2'(q_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= cls;
    end
  end

endmodule

>>> rtl/swse_back.sv
module swse_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     x_off,
  input  logic [7:0]     y_off,
  input  logic [10:0]    scr_w,
  input  logic [10:0]    scr_h,
  input  logic           q_valid,
  input  swse_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    x_start,
  output logic [15:0]    x_end,
  output logic [15:0]    y_start,
  output logic [15:0]    y_end,
  output logic [15:0]    pixel_color,
  output logic           draw,
  output logic           last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_SPAN = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  localparam logic [1:0] PH_BAND   = 2'd0;
  localparam logic [1:0] PH_TOP    = 2'd1;
  localparam logic [1:0] PH_BOTTOM = 2'd2;

  logic [2:0]         state;
  swse_pkg::cmd_t     cmd;
  logic signed [5:0]  idx;
  logic [1:0]         phase;
  logic [2:0]         cell_col;
  logic [2:0]         cell_row;
  logic [9:0]         rem;
  logic [4:0]         root;
  logic [2:0]         sq_bit;
  logic signed [16:0] sp_x;
  logic signed [16:0] sp_y;
  logic signed [16:0] sp_w;
  logic signed [16:0] sp_h;
  logic [15:0]        sp_col;
  logic               sp_clip;

  logic signed [5:0]  r_s;
  logic               is_last;
  logic [9:0]         r_sq;
  logic signed [11:0] idx_sq;
  logic [4:0]         trial;
  logic [9:0]         trial_sq;
  logic [9:0]         root_sq;

  logic signed [16:0] px_e, py_e, w_e, h_e, dx_e, r_e, idx_e;
  logic [6:0]         cx_off;
  logic [6:0]         cy_off;
  logic [7:0]         col_byte;
  logic signed [16:0] nx, ny, nw, nh;
  logic [15:0]        ncol;

  logic signed [16:0] xc, yc, wc, hc, sw_e, sh_e, xe_c, ye_c;
  logic               e_draw;
  logic [15:0]        e_xs, e_xe, e_ys, e_ye;
  logic               out_load;

  // Square-root helpers: remainder and one trial bit per step.
  always_comb begin
    r_s      = signed'({1'b0, cmd.radius});
    r_sq     = {5'd0, cmd.radius} * {5'd0, cmd.radius};
    idx_sq   = 12'(idx * idx);
    trial    = root | (5'd1 << sq_bit);
    trial_sq = {5'd0, trial} * {5'd0, trial};
    root_sq  = {5'd0, root} * {5'd0, root};
  end

  // Final span of a command.
  always_comb begin
    unique case (cmd.opcode)
      swse_pkg::OP_RECT:   is_last = 1'b1;
      swse_pkg::OP_CIRCLE: is_last = (idx == r_s);
      swse_pkg::OP_RRECT:  is_last = (phase == PH_BOTTOM) && (idx == r_s);
      default:             is_last = (cell_col == 3'(swse_pkg::GLYPH_COLS - 1)) &&
                                     (cell_row == 3'(swse_pkg::GLYPH_ROWS - 1));
    endcase
  end

  // Span geometry for the current step.
  always_comb begin
    px_e     = 17'(cmd.pos_x);
    py_e     = 17'(cmd.pos_y);
    w_e      = 17'(cmd.width);
    h_e      = 17'(cmd.height);
    dx_e     = {12'd0, root};
    r_e      = {12'd0, cmd.radius};
    idx_e    = 17'(idx);
    cx_off   = 7'({4'd0, cell_col} * {3'd0, cmd.scale});
    cy_off   = 7'({4'd0, cell_row} * {3'd0, cmd.scale});
    col_byte = swse_pkg::glyph_column(cmd.glyph, cell_col);
    nx       = px_e;
    ny       = py_e;
    nw       = w_e;
    nh       = h_e;
    ncol     = cmd.fg_color;
    unique case (cmd.opcode)
      swse_pkg::OP_RECT: begin
      end
      swse_pkg::OP_CIRCLE: begin
        nx = px_e - dx_e;
        ny = py_e + idx_e;
        nw = (dx_e <<< 1) + 17'sd1;
        nh = 17'sd1;
      end
      swse_pkg::OP_RRECT: begin
        if (phase == PH_BAND) begin
          ny = py_e + r_e;
          nh = h_e - (r_e <<< 1);
        end else begin
          nx = px_e + r_e - dx_e;
          nw = (dx_e <<< 1) + w_e - (r_e <<< 1);
          nh = 17'sd1;
          if (phase == PH_TOP) begin
            ny = py_e + r_e - idx_e;
          end else begin
            ny = py_e + h_e - 17'sd1 - r_e + idx_e;
          end
        end
      end
      default: begin
        nx   = px_e + {10'd0, cx_off};
        ny   = py_e + {10'd0, cy_off};
        nw   = {13'd0, cmd.scale};
        nh   = {13'd0, cmd.scale};
        ncol = col_byte[cell_row] ? cmd.fg_color : cmd.bg_color;
      end
    endcase
  end

  // Clipping of the registered span (circles and rounded rectangles); offsets are added at the output register.
  always_comb begin
    sw_e = {6'd0, scr_w};
    sh_e = {6'd0, scr_h};
    xc   = (sp_x < 0) ? 17'sd0 : sp_x;
    wc   = (sp_x < 0) ? sp_w + sp_x : sp_w;
    yc   = (sp_y < 0) ? 17'sd0 : sp_y;
    hc   = (sp_y < 0) ? sp_h + sp_y : sp_h;
    xe_c = (xc + wc > sw_e) ? sw_e - 17'sd1 : xc + wc - 17'sd1;
    ye_c = (yc + hc > sh_e) ? sh_e - 17'sd1 : yc + hc - 17'sd1;
    if (sp_clip) begin
      e_draw = (wc > 0) && (hc > 0) && (xc < sw_e) && (yc < sh_e);
      e_xs   = xc[15:0];
      e_xe   = xe_c[15:0];
      e_ys   = yc[15:0];
      e_ye   = ye_c[15:0];
    end else begin
      e_draw = (sp_w > 0) && (sp_h > 0);
      e_xs   = sp_x[15:0];
      e_xe   = 16'(sp_x + sp_w - 17'sd1);
      e_ys   = sp_y[15:0];
      e_ye   = 16'(sp_y + sp_h - 17'sd1);
    end
  end

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_load = (state == S_EMIT) && (!out_valid || out_ready);

  // Sequencer: walks the spans of one command.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_cmd.opcode == swse_pkg::OP_CIRCLE) begin
              state <= S_PREP;
            end else begin
              state <= S_SPAN;
            end
          end
        end
        S_PREP: state <= S_SQRT;
        S_SQRT: begin
          if (sq_bit == 3'd0) begin
            state <= S_SPAN;
          end
        end
        S_SPAN: state <= S_EMIT;
        default: begin
          if (out_load) begin
            if (is_last) begin
              state <= S_IDLE;
            end else if (cmd.opcode == swse_pkg::OP_CHAR ||
                         (cmd.opcode == swse_pkg::OP_RRECT && phase == PH_TOP)) begin
              state <= S_SPAN;
            end else begin
              state <= S_PREP;
            end
          end
        end
      endcase
    end
  end

  // Command, counters and datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cmd      <= q_cmd;
        idx      <= -signed'({1'b0, q_cmd.radius});
        phase    <= PH_BAND;
        cell_col <= 3'd0;
        cell_row <= 3'd0;
        root     <= 5'd0;
      end
      S_PREP: begin
        rem    <= r_sq - idx_sq[9:0];
        root   <= 5'd0;
        sq_bit <= 3'd4;
      end
      S_SQRT: begin
        if (trial_sq <= rem) begin
          root <= trial;
        end
        sq_bit <= sq_bit - 3'd1;
      end
      S_SPAN: begin
        sp_x    <= nx;
        sp_y    <= ny;
        sp_w    <= nw;
        sp_h    <= nh;
        sp_col  <= ncol;
        sp_clip <= (cmd.opcode == swse_pkg::OP_CIRCLE) || (cmd.opcode == swse_pkg::OP_RRECT);
      end
      default: begin
        if (out_load && !is_last) begin
          if (cmd.opcode == swse_pkg::OP_CHAR) begin
            if (cell_row == 3'(swse_pkg::GLYPH_ROWS - 1)) begin
              cell_row <= 3'd0;
              cell_col <= cell_col + 3'd1;
            end else begin
              cell_row <= cell_row + 3'd1;
            end
          end else if (cmd.opcode == swse_pkg::OP_RRECT) begin
            if (phase == PH_BAND) begin
              phase <= PH_TOP;
              idx   <= 6'sd0;
            end else if (phase == PH_TOP) begin
              phase <= PH_BOTTOM;
            end else begin
              phase <= PH_TOP;
              idx   <= idx + 6'sd1;
            end
          end else begin
            idx <= idx + 6'sd1;
          end
        end
      end
    endcase
  end

  // Output register: holds one result while the next span is prepared.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      x_start     <= e_draw ? e_xs + {8'd0, x_off} : 16'd0;
      x_end       <= e_draw ? e_xe + {8'd0, x_off} : 16'd0;
      y_start     <= e_draw ? e_ys + {8'd0, y_off} : 16'd0;
      y_end       <= e_draw ? e_ye + {8'd0, y_off} : 16'd0;
      pixel_color <= e_draw ? sp_col : 16'd0;
      draw        <= e_draw;
      last        <= is_last;
    end
  end

  // A command leaves the queue only when the sequencer is free.
  assert property (@(posedge clk) disable iff (rst) q_pop |-> (state == S_IDLE) && q_valid)
    else $error("queue popped while sequencer busy");

  // The partial root never overshoots the remainder.
  assert property (@(posedge clk) disable iff (rst) (state == S_SQRT) |-> (root_sq <= rem))
    else $error("square root step overshoot");

  // A new result appears only out of the emit step.
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(state) == S_EMIT)
    else $error("result loaded outside emit step");

endmodule
